>>> design/crt_pkg.sv
package crt_pkg;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_REJECTED = 2'd2,
    ST_TICK     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHUNK,
    S_SWEEP
  } ctrl_state_e;

  localparam logic        OP_CHUNK      = 1'b0;
  localparam logic        OP_TICK       = 1'b1;
  localparam logic        REG_TIMEOUT   = 1'b0;
  localparam logic [31:0] TIMEOUT_RESET = 32'd15000;
  localparam logic [4:0]  DROP_MAX      = 5'd31;

  typedef struct packed {
    logic [3:0]  slot;
    logic [63:0] hash;
    logic [7:0]  seq;
    logic [7:0]  total;
  } chunk_req_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [7:0]  expected;
    logic [7:0]  held;
  } slot_hdr_t;

  typedef struct packed {
    status_e    status;
    logic       restarted;
    logic [7:0] held;
    logic       reject;
    logic       complete;
  } chunk_res_t;

endpackage

>>> design/crt_slot_ram.sv
module crt_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 240,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/crt_chunk_update.sv
module crt_chunk_update import crt_pkg::*; #(
  parameter int NUM_SENDERS = 16,
  parameter int MAX_CHUNKS  = 128
) (
  input  chunk_req_t            req_i,
  input  logic                  active_i,
  input  slot_hdr_t             hdr_i,
  input  logic [MAX_CHUNKS-1:0] bitmap_i,
  output slot_hdr_t             hdr_o,
  output logic [MAX_CHUNKS-1:0] bitmap_o,
  output chunk_res_t            res_o
);

  localparam int          BW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam logic [8:0]  NS   = 9'(NUM_SENDERS);
  localparam logic [7:0]  MAXC = 8'(MAX_CHUNKS);

  logic                  reject;
  logic                  restart;
  logic                  hit;
  logic                  complete;
  logic [BW-1:0]         idx;
  logic [MAX_CHUNKS-1:0] base_bitmap;
  logic [7:0]            base_held;
  logic [7:0]            held_new;

  always_comb begin
    reject = (req_i.hash == 64'd0) || (req_i.total == 8'd0) || (req_i.total > MAXC) ||
             (req_i.seq >= req_i.total) || ({5'd0, req_i.slot} >= NS);
    restart = !active_i || (hdr_i.hash != req_i.hash) || (hdr_i.expected != req_i.total);
    base_bitmap = restart ? '0 : bitmap_i;
    base_held   = restart ? 8'd0 : hdr_i.held;
    idx         = req_i.seq[BW-1:0];
    hit         = base_bitmap[idx];
    held_new    = hit ? base_held : base_held + 8'd1;
    complete    = held_new >= req_i.total;

    bitmap_o      = base_bitmap | (MAX_CHUNKS'(1) << idx);
    hdr_o.hash     = req_i.hash;
    hdr_o.expected = req_i.total;
    hdr_o.held     = held_new;

    res_o.reject    = reject;
    res_o.complete  = !reject && complete;
    res_o.restarted = !reject && restart;
    res_o.held      = reject ? 8'd0 : held_new;
    priority if (reject) begin
      res_o.status = ST_REJECTED;
    end else if (complete) begin
      res_o.status = ST_COMPLETE;
    end else begin
      res_o.status = ST_STORED;
    end
  end

endmodule

>>> design/chunk_reassembly_tracker_unit.sv
// Chunk reassembly tracker: one reassembly slot per sender, held in a slot memory.
// Command channel: a transaction is taken when start is high and busy is low.
// operation_i selects a chunk arrival or a time tick with a stale-slot sweep.
// Result channel: done_o is high for one cycle with status_o, slot_restarted_o,
// chunks_held_o and slots_dropped_o; the receiver cannot stall, so each result
// is taken in that cycle while the next command may already be accepted.
// Chunk arrival: one slot memory read, then a write back unless the chunk is
// rejected or completes the slot; the result appears in the cycle after that state.
// Tick: one slot age check per cycle through the memory read port; the result
// appears in the cycle after the last check.
// The stale timeout register lies at byte address 0 of the APB port; writes
// complete in the access cycle, pready is always high.
// Reset: every slot is free (valid flags cleared at once), time is zero and
// the timeout is 15000 ticks; no clearing pass is needed.
module chunk_reassembly_tracker_unit import crt_pkg::*; #(
  parameter int NUM_SENDERS = 16,
  parameter int MAX_CHUNKS  = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [3:0]  sender_slot_i,
  input  logic [63:0] snapshot_hash_i,
  input  logic [7:0]  chunk_sequence_i,
  input  logic [7:0]  chunk_total_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        slot_restarted_o,
  output logic [7:0]  chunks_held_o,
  output logic [4:0]  slots_dropped_o
);

  localparam int AW  = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int HW  = $bits(slot_hdr_t);
  localparam int EW  = HW + 32 + MAX_CHUNKS;
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SENDERS - 1);

  ctrl_state_e state_q, state_d;

  logic [31:0]            timeout_q;
  logic [31:0]            time_q;
  logic [NUM_SENDERS-1:0] active_q;
  logic [AW-1:0]          sweep_q;
  logic [4:0]             drop_cnt_q, drop_cnt_d;
  logic                   done_q;
  status_e                status_q, status_d;
  logic                   restarted_q, restarted_d;
  logic [7:0]             held_q, held_d;
  logic [4:0]             dropped_q, dropped_d;
  chunk_req_t             req_q;

  logic                   accept;
  logic                   cfg_write;
  logic                   sweep_last;
  logic                   mem_we;
  logic [AW-1:0]          mem_raddr;
  logic [AW-1:0]          req_addr;
  logic [EW-1:0]          mem_wdata;
  logic [EW-1:0]          mem_rdata;

  slot_hdr_t              rd_hdr, wr_hdr;
  logic [31:0]            rd_last;
  logic [MAX_CHUNKS-1:0]  rd_bitmap, wr_bitmap;
  chunk_res_t             upd_res;
  logic                   stale;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_TIMEOUT) ? timeout_q : 32'd0;
  assign req_addr  = AW'(req_q.slot);

  assign rd_hdr    = mem_rdata[EW-1 -: HW];
  assign rd_last   = mem_rdata[MAX_CHUNKS +: 32];
  assign rd_bitmap = mem_rdata[MAX_CHUNKS-1:0];
  assign mem_wdata = {wr_hdr, time_q, wr_bitmap};

  crt_slot_ram #(
    .DEPTH (NUM_SENDERS),
    .WIDTH (EW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (req_addr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  crt_chunk_update #(
    .NUM_SENDERS (NUM_SENDERS),
    .MAX_CHUNKS  (MAX_CHUNKS)
  ) u_update (
    .req_i    (req_q),
    .active_i (active_q[req_addr]),
    .hdr_i    (rd_hdr),
    .bitmap_i (rd_bitmap),
    .hdr_o    (wr_hdr),
    .bitmap_o (wr_bitmap),
    .res_o    (upd_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (operation_i == OP_TICK) ? S_SWEEP : S_CHUNK;
        end
      end
      S_CHUNK: state_d = S_IDLE;
      S_SWEEP: begin
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    mem_we     = 1'b0;
    mem_raddr  = sweep_q + AW'(1);
    sweep_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy      = 1'b0;
        mem_raddr = (operation_i == OP_TICK) ? '0 : AW'(sender_slot_i);
      end
      S_CHUNK: mem_we = !upd_res.reject && !upd_res.complete;
      S_SWEEP: sweep_last = (sweep_q == LAST_SLOT);
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    stale = active_q[sweep_q] && ((time_q - rd_last) > timeout_q);
    drop_cnt_d = drop_cnt_q;
    if (stale && (drop_cnt_q != DROP_MAX)) begin
      drop_cnt_d = drop_cnt_q + 5'd1;
    end
    status_d    = status_q;
    restarted_d = restarted_q;
    held_d      = held_q;
    dropped_d   = dropped_q;
    if (state_q == S_CHUNK) begin
      status_d    = upd_res.status;
      restarted_d = upd_res.restarted;
      held_d      = upd_res.held;
      dropped_d   = 5'd0;
    end else if (state_q == S_SWEEP) begin
      status_d    = ST_TICK;
      restarted_d = 1'b0;
      held_d      = 8'd0;
      dropped_d   = drop_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      timeout_q  <= TIMEOUT_RESET;
      time_q     <= 32'd0;
      active_q   <= '0;
      sweep_q    <= '0;
      drop_cnt_q <= 5'd0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_CHUNK) || sweep_last;
      if (cfg_write && (paddr[2] == REG_TIMEOUT)) begin
        timeout_q <= pwdata;
      end
      if (accept && (operation_i == OP_TICK)) begin
        time_q     <= time_q + 32'd1;
        sweep_q    <= '0;
        drop_cnt_q <= 5'd0;
      end
      if (state_q == S_SWEEP) begin
        sweep_q    <= sweep_q + AW'(1);
        drop_cnt_q <= drop_cnt_d;
        if (stale) begin
          active_q[sweep_q] <= 1'b0;
        end
      end
      if ((state_q == S_CHUNK) && !upd_res.reject) begin
        active_q[req_addr] <= !upd_res.complete;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= '{slot: sender_slot_i, hash: snapshot_hash_i,
                 seq: chunk_sequence_i, total: chunk_total_i};
    end
    status_q    <= status_d;
    restarted_q <= restarted_d;
    held_q      <= held_d;
    dropped_q   <= dropped_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign slot_restarted_o = restarted_q;
  assign chunks_held_o    = held_q;
  assign slots_dropped_o  = dropped_q;

  a_done_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q != S_IDLE))
    else $error("result strobe without work in progress");

  a_tick_enters_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_TICK)) |=> (state_q == S_SWEEP))
    else $error("tick transaction did not start the sweep");

  a_complete_has_chunks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_COMPLETE)) |-> (chunks_held_o != 8'd0))
    else $error("completion reported with no chunks held");

  a_reject_frees_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHUNK) && upd_res.reject) |=> $stable(active_q))
    else $error("rejected chunk changed slot occupancy");

endmodule
